// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands, sampled on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ===== rtl/ict_pkg.sv =====
// ----------------------------------------------------------------------------
// ict_pkg
// Constants and codes for the interval timer channel.
// ----------------------------------------------------------------------------
package ict_pkg;

    localparam int ICT_COUNT_WIDTH = 16;

    // request kinds
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // port offsets
    localparam logic [1:0] PORT_DATA = 2'd0;
    localparam logic [1:0] PORT_CTRL = 2'd3;

    // control word fields
    localparam logic [1:0] SEL_CNT0     = 2'b00;
    localparam logic [1:0] SEL_READBACK = 2'b11;
    localparam logic [7:0] ACCESS_MASK  = 8'h30;
    localparam logic [7:0] RB_CNT0_BIT  = 8'h02;
    localparam logic [7:0] RB_COUNT_BIT = 8'h20;
    localparam logic [1:0] MODE_RATE    = 2'b10;

endpackage

// ===== rtl/interval_timer_channel.sv =====
// ----------------------------------------------------------------------------
// interval_timer_channel
// Counter 0 of an 8254-style timer: modes 0 and 2, low/high byte access.
// ----------------------------------------------------------------------------
// One transfer is taken every clock when the output side keeps up. Each
// transfer is registered in the input register, processed against the
// counter state, and its result is registered in the output register, so
// throughput is one item per cycle unless the output stalls. A tick
// decrements the count, a write on port 3 programs the mode or latches the
// count, writes on port 0 load the count low byte then high byte (the high
// byte starts counting, zero means the full range), and reads on port 0
// return the latched or live count low byte then high byte.
module interval_timer_channel #(
    parameter int COUNT_WIDTH = ict_pkg::ICT_COUNT_WIDTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] wdata
    input  logic [3:0]  s_tuser,   // [1:0] req_type, [3:2] port
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [7:0] rdata, [8] irq_pulse, [9] out_level
);

    import ict_pkg::*;

    localparam int W = COUNT_WIDTH;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [1:0] in_req_reg;
    logic [1:0] in_port_reg;
    logic [7:0] in_wdata_reg;

    // counter state
    logic         periodic_mode_reg, periodic_mode_next;
    logic [W-1:0] reload_value_reg, reload_value_next;
    logic [W-1:0] count_now_reg, count_now_next;
    logic [W-1:0] latched_count_reg, latched_count_next;
    logic         latch_held_reg, latch_held_next;
    logic         write_high_reg, write_high_next;
    logic         read_high_reg, read_high_next;
    logic         counting_reg, counting_next;
    logic         output_pin_reg, output_pin_next;

    // result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] rdata_reg, rdata_next;
    logic       irq_reg, irq_next;
    logic       level_reg;

    logic advance;
    logic take;
    logic do_latch;

    logic [15:0] reload16;
    logic [15:0] src16;
    logic [15:0] load16;
    logic [W-1:0] count_dec;

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign take     = s_tvalid && s_tready;

    assign reload16  = 16'(reload_value_reg);
    assign src16     = latch_held_reg ? 16'(latched_count_reg) : 16'(count_now_reg);
    assign count_dec = count_now_reg - W'(1);

    always_comb
    begin
        in_valid_next      = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next     = advance ? in_valid_reg : out_valid_reg;

        periodic_mode_next = periodic_mode_reg;
        reload_value_next  = reload_value_reg;
        count_now_next     = count_now_reg;
        latched_count_next = latched_count_reg;
        latch_held_next    = latch_held_reg;
        write_high_next    = write_high_reg;
        read_high_next     = read_high_reg;
        counting_next      = counting_reg;
        output_pin_next    = output_pin_reg;
        rdata_next         = 8'd0;
        irq_next           = 1'b0;
        do_latch           = 1'b0;
        load16             = 16'd0;

        if (in_valid_reg && advance)
        begin
            unique case (in_req_reg)
                REQ_TICK:
                begin
                    if (counting_reg)
                    begin
                        if (!periodic_mode_reg)
                        begin
                            count_now_next = count_dec;
                            if (count_dec == '0 && !output_pin_reg)
                            begin
                                output_pin_next = 1'b1;
                                irq_next        = 1'b1;
                            end
                        end
                        else if (count_now_reg == W'(1))
                        begin
                            count_now_next  = reload_value_reg;
                            output_pin_next = 1'b1;
                            irq_next        = 1'b1;
                        end
                        else
                        begin
                            count_now_next  = count_dec;
                            output_pin_next = (count_dec != W'(1));
                        end
                    end
                end
                REQ_WRITE:
                begin
                    if (in_port_reg == PORT_CTRL)
                    begin
                        if (in_wdata_reg[7:6] == SEL_READBACK)
                        begin
                            do_latch = ((in_wdata_reg & RB_CNT0_BIT) != 8'd0) &&
                                       ((in_wdata_reg & RB_COUNT_BIT) == 8'd0);
                        end
                        else if (in_wdata_reg[7:6] == SEL_CNT0)
                        begin
                            if ((in_wdata_reg & ACCESS_MASK) == 8'd0)
                            begin
                                do_latch = 1'b1;
                            end
                            else
                            begin
                                periodic_mode_next = (in_wdata_reg[2:1] == MODE_RATE);
                                counting_next      = 1'b0;
                                write_high_next    = 1'b0;
                                read_high_next     = 1'b0;
                                latch_held_next    = 1'b0;
                                output_pin_next    = (in_wdata_reg[2:1] == MODE_RATE);
                            end
                        end
                    end
                    else if (in_port_reg == PORT_DATA)
                    begin
                        if (!write_high_reg)
                        begin
                            load16            = {reload16[15:8], in_wdata_reg};
                            reload_value_next = load16[W-1:0];
                            if (!periodic_mode_reg)
                            begin
                                counting_next = 1'b0;
                            end
                            write_high_next = 1'b1;
                        end
                        else
                        begin
                            load16            = {in_wdata_reg, reload16[7:0]};
                            reload_value_next = load16[W-1:0];
                            count_now_next    = load16[W-1:0];
                            counting_next     = 1'b1;
                            write_high_next   = 1'b0;
                            output_pin_next   = periodic_mode_reg;
                        end
                    end
                end
                REQ_READ:
                begin
                    if (in_port_reg == PORT_DATA)
                    begin
                        if (!read_high_reg)
                        begin
                            rdata_next     = src16[7:0];
                            read_high_next = 1'b1;
                        end
                        else
                        begin
                            rdata_next      = src16[15:8];
                            read_high_next  = 1'b0;
                            latch_held_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (do_latch && !latch_held_reg)
            begin
                latched_count_next = count_now_reg;
                latch_held_next    = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            periodic_mode_reg <= 1'b0;
            reload_value_reg  <= '0;
            count_now_reg     <= '0;
            latched_count_reg <= '0;
            latch_held_reg    <= 1'b0;
            write_high_reg    <= 1'b0;
            read_high_reg     <= 1'b0;
            counting_reg      <= 1'b0;
            output_pin_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            periodic_mode_reg <= periodic_mode_next;
            reload_value_reg  <= reload_value_next;
            count_now_reg     <= count_now_next;
            latched_count_reg <= latched_count_next;
            latch_held_reg    <= latch_held_next;
            write_high_reg    <= write_high_next;
            read_high_reg     <= read_high_next;
            counting_reg      <= counting_next;
            output_pin_reg    <= output_pin_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_req_reg   <= s_tuser[1:0];
            in_port_reg  <= s_tuser[3:2];
            in_wdata_reg <= s_tdata;
        end
        if (in_valid_reg && advance)
        begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
            level_reg <= output_pin_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, level_reg, irq_reg, rdata_reg};

endmodule

// ===== rtl/ict_checker.sv =====
// ----------------------------------------------------------------------------
// ict_checker
// Port-level assertions for the interval timer channel, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ict_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,   // [7:0] wdata
    input logic [3:0]  s_tuser,   // [1:0] req_type, [3:2] port
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata    // [7:0] rdata, [8] irq_pulse, [9] out_level
);

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready && (s_tuser != 4'hF || s_tdata != 8'hFF);

    // an interrupt only comes with the output high
    `ASSERT_IMPLIES(a_irq_level, m_tvalid && m_tdata[8], m_tdata[9])
    // padding bits stay clear
    `ASSERT_IMPLIES(a_pad_zero, m_tvalid || in_xfer, m_tdata[15:10] == 6'd0 || !m_tvalid)
    // an empty output stage never blocks the input side
    `ASSERT_IMPLIES(a_ready_when_empty, !m_tvalid, s_tready)
    // a stalled result holds
    `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind interval_timer_channel ict_checker u_ict_checker (.*);
